// ----- hw/rtl/lcc_pkg.sv -----
// Shared types and constants for the line-follow course controller.
package lcc_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int HALF_SENSORS = NUM_SENSORS / 2;
    localparam int THR_W = 10;
    localparam int GAIN_W = 12;
    localparam int SPEED_W = 8;
    localparam int STEER_W = 16;
    localparam int MODE_W = 3;
    localparam int TIME_W = 32;
    localparam int QUO_W = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_TDATA_W = 32;
    localparam int DARK_W = 4;
    localparam int SIDE_W = 3;

    localparam logic [TIME_W-1:0] T_BRAKE_MS = 32'd100;
    localparam logic [TIME_W-1:0] T_SETTLE_MS = 32'd200;
    localparam logic [TIME_W-1:0] T_HARD_TURN_MS = 32'd450;
    localparam logic [TIME_W-1:0] T_EXIT_MS = 32'd700;
    localparam logic [TIME_W-1:0] T_TURN_END_MS = 32'd800;
    localparam logic [TIME_W-1:0] T_DETECT_MS = 32'd2500;

    localparam logic signed [STEER_W-1:0] STEER_HARD = 16'sd40;
    localparam logic signed [STEER_W-1:0] STEER_BACK = 16'sd20;

    localparam logic [DARK_W-1:0] DARK_ALL_MIN = 4'd6;
    localparam logic [DARK_W-1:0] DARK_TURN_MIN = 4'd2;
    localparam logic [SIDE_W-1:0] SIDE_MIN = 3'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DARK_THR  = 3'd0,
        REG_STRICT    = 3'd1,
        REG_LOOSE     = 3'd2,
        REG_FAST      = 3'd3,
        REG_MEDIUM    = 3'd4,
        REG_SLOW      = 3'd5,
        REG_BRAKE     = 3'd6
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FOLLOW     = 3'd0,
        MODE_CORNER_IN  = 3'd1,
        MODE_CORNER_OUT = 3'd2,
        MODE_RIGHT_DET  = 3'd3,
        MODE_RIGHT_TURN = 3'd4,
        MODE_LEFT_DET   = 3'd5,
        MODE_LEFT_TURN  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        DET_NONE   = 2'd0,
        DET_CORNER = 2'd1,
        DET_RIGHT  = 2'd2,
        DET_LEFT   = 2'd3
    } det_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MERGE = 3'd1,
        ST_START = 3'd2,
        ST_DIV   = 3'd3,
        ST_DONE  = 3'd4
    } st_t;

    typedef struct packed {
        logic [DARK_W-1:0] dark;
        logic [SIDE_W-1:0] left;
        logic [SIDE_W-1:0] right;
    } counts_t;

endpackage

// ----- hw/rtl/line_follow_course_controller.sv -----
// Top level: sensor lanes, merge stage, steering divider and course state machine.
//
// Usage: one word on s_axis per control tick carries eight sensor readings
// and the millisecond timestamp; one word on m_axis returns drive speed,
// held steering value and the mode after the tick. Configuration registers
// are written through cfg_wr_en / cfg_wr_addr / cfg_wr_data; the user must
// write them only while idle, which the block itself does not enforce.
// An accepted word passes through the merge, the divider start, the gain
// multiply, the 14-step restoring divide and the state update into the
// output register. The block holds one word at a time, so a new word is
// taken only after the previous one has been committed to the output register.
// Reset clears the course state (follow mode, no detection, timestamp and
// steering zero) and loads the register defaults. A stalled receiver holds
// the result in the output register; the next input word is still taken
// and worked on, and its result waits until the register is free.
module line_follow_course_controller
    import lcc_pkg::*;
#(
    parameter int SENSOR_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sensor_0 .. sensor_7 (SENSOR_BITS each), now_ms (32)
    input  logic [NUM_SENSORS*SENSOR_BITS+TIME_W-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // drive_speed (8), steer (16), mode_after (3), zero fill (5)
    output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                  cfg_wr_addr,
    input  logic [CFG_DATA_W-1:0]                  cfg_wr_data
);
    localparam int SB = SENSOR_BITS;

    // configuration
    logic [THR_W-1:0]          thr_reg;
    logic [GAIN_W-1:0]         strict_reg, loose_reg;
    logic signed [SPEED_W-1:0] fast_reg, medium_reg, slow_reg, brake_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 10'd400;
            strict_reg <= 12'd2000;
            loose_reg <= 12'd20;
            fast_reg <= 8'sd30;
            medium_reg <= 8'sd20;
            slow_reg <= 8'sd10;
            brake_reg <= -8'sd40;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_wr_addr))
                REG_DARK_THR: thr_reg <= cfg_wr_data[THR_W-1:0];
                REG_STRICT:   strict_reg <= cfg_wr_data;
                REG_LOOSE:    loose_reg <= cfg_wr_data;
                REG_FAST:     fast_reg <= cfg_wr_data[SPEED_W-1:0];
                REG_MEDIUM:   medium_reg <= cfg_wr_data[SPEED_W-1:0];
                REG_SLOW:     slow_reg <= cfg_wr_data[SPEED_W-1:0];
                REG_BRAKE:    brake_reg <= cfg_wr_data[SPEED_W-1:0];
                default:      ;
            endcase
        end
    end

    // input capture
    logic [NUM_SENSORS-1:0][SB-1:0] samples_reg;
    logic [TIME_W-1:0]              now_reg;
    logic                           in_acc;

    st_t state_reg, state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
                samples_reg[i] <= s_axis_tdata[i*SB +: SB];
            now_reg <= s_axis_tdata[NUM_SENSORS*SB +: TIME_W];
        end
    end

    // lanes and merge
    logic [NUM_SENSORS-1:0][SB+2:0] weighted;
    logic [NUM_SENSORS-1:0]         dark_bits;
    logic [SB+2:0]                  sum;
    logic [SB+4:0]                  wsum;
    counts_t                        counts;

    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_lane
        lcc_lane #(
            .SENSOR_BITS(SB),
            .LANE(g)
        ) u_lane (
            .sample(samples_reg[g]),
            .thr(thr_reg),
            .dark(dark_bits[g]),
            .weighted(weighted[g])
        );
    end

    lcc_merge #(
        .SENSOR_BITS(SB)
    ) u_merge (
        .clk(clk),
        .load(state_reg == ST_MERGE),
        .samples(samples_reg),
        .weighted(weighted),
        .dark(dark_bits),
        .sum(sum),
        .wsum(wsum),
        .counts(counts)
    );

    // course state
    mode_t                     mode_reg, mode_next;
    det_t                      det_reg, det_next;
    logic [TIME_W-1:0]         event_reg, event_next;
    logic signed [STEER_W-1:0] steer_reg, steer_next;
    logic signed [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]         elapsed;
    logic [GAIN_W-1:0]         gain;
    logic                      div_start, div_busy, div_done;
    logic signed [STEER_W-1:0] quotient;
    logic                      out_full_reg;
    logic [OUT_TDATA_W-1:0]    out_data_reg;
    logic                      out_free, commit;

    always_comb
    begin
        case (mode_reg)
            MODE_CORNER_IN, MODE_RIGHT_DET, MODE_LEFT_DET: gain = loose_reg;
            default:                                       gain = strict_reg;
        endcase
    end

    assign div_start = (state_reg == ST_START);

    lcc_divider #(
        .SENSOR_BITS(SB)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .gain(gain),
        .sum(sum),
        .wsum(wsum),
        .busy(div_busy),
        .done(div_done),
        .quotient(quotient)
    );

    assign elapsed = now_reg - event_reg;
    assign out_free = !out_full_reg || m_axis_tready;

    // sequencer and mode update
    always_comb
    begin
        state_next = state_reg;
        commit = 1'b0;
        mode_next = mode_reg;
        det_next = det_reg;
        event_next = event_reg;
        steer_next = steer_reg;
        speed = medium_reg;

        case (mode_reg)
            MODE_CORNER_IN:
            begin
                speed = (elapsed < T_BRAKE_MS) ? brake_reg : slow_reg;
                steer_next = quotient;
                if (elapsed > T_SETTLE_MS && (counts.left > SIDE_MIN
                    || counts.right > SIDE_MIN))
                begin
                    event_next = now_reg;
                    mode_next = MODE_CORNER_OUT;
                end
            end
            MODE_CORNER_OUT:
            begin
                steer_next = quotient;
                if (elapsed > T_EXIT_MS)
                begin
                    event_next = now_reg;
                    mode_next = MODE_FOLLOW;
                end
            end
            MODE_RIGHT_DET, MODE_LEFT_DET:
            begin
                steer_next = quotient;
                // line lost: start the turn; otherwise give up after the window
                if (counts.dark == '0)
                begin
                    event_next = now_reg;
                    mode_next = (mode_reg == MODE_RIGHT_DET) ? MODE_RIGHT_TURN
                                                             : MODE_LEFT_TURN;
                end
                else if (elapsed > T_DETECT_MS)
                begin
                    event_next = now_reg;
                    mode_next = MODE_FOLLOW;
                end
            end
            MODE_RIGHT_TURN, MODE_LEFT_TURN:
            begin
                if (elapsed < T_HARD_TURN_MS)
                    steer_next = (mode_reg == MODE_RIGHT_TURN) ? -STEER_HARD : STEER_HARD;
                else if (elapsed < T_TURN_END_MS)
                    steer_next = (mode_reg == MODE_RIGHT_TURN) ? STEER_BACK : -STEER_BACK;
                else if (counts.dark > DARK_TURN_MIN)
                begin
                    event_next = now_reg;
                    mode_next = MODE_FOLLOW;
                end
            end
            default:
            begin
                mode_next = MODE_FOLLOW;
                speed = fast_reg;
                steer_next = quotient;
                if (counts.dark > DARK_ALL_MIN)
                begin
                    if (det_reg == DET_CORNER)
                    begin
                        event_next = now_reg;
                        mode_next = MODE_CORNER_IN;
                    end
                    det_next = DET_CORNER;
                end
                else if (elapsed > T_SETTLE_MS && counts.right > SIDE_MIN)
                begin
                    if (det_reg == DET_RIGHT)
                    begin
                        event_next = now_reg;
                        mode_next = MODE_RIGHT_DET;
                    end
                    det_next = DET_RIGHT;
                end
                else if (elapsed > T_SETTLE_MS && counts.left > SIDE_MIN)
                begin
                    if (det_reg == DET_LEFT)
                    begin
                        event_next = now_reg;
                        mode_next = MODE_LEFT_DET;
                    end
                    det_next = DET_LEFT;
                end
            end
        endcase

        case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = ST_MERGE;
            ST_MERGE:
                state_next = ST_START;
            ST_START:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                // hold until the output register can take the word
                if (out_free)
                begin
                    commit = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FOLLOW;
            det_reg <= DET_NONE;
            event_reg <= '0;
            steer_reg <= '0;
        end
        else if (commit)
        begin
            mode_reg <= mode_next;
            det_reg <= det_next;
            event_reg <= event_next;
            steer_reg <= steer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (commit)
            out_full_reg <= 1'b1;
        else if (m_axis_tready)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_data_reg <= {5'b0, mode_next, steer_next, speed};
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata = out_data_reg;

`ifndef NO_ASSERTIONS
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_busy)
        else $error("divider running while input side is open");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done) |=> (state_reg == ST_DONE))
        else $error("sequencer missed divider completion");
`endif

endmodule

// ----- hw/rtl/lcc_lane.sv -----
// One sensor lane: dark test and position-weighted reading.
module lcc_lane
    import lcc_pkg::*;
#(
    parameter int SENSOR_BITS = 10,
    parameter int LANE = 0
) (
    input  logic [SENSOR_BITS-1:0] sample,
    input  logic [THR_W-1:0]       thr,
    output logic                   dark,
    output logic [SENSOR_BITS+2:0] weighted
);
    localparam int CW = (SENSOR_BITS > THR_W) ? SENSOR_BITS : THR_W;
    localparam int WW = SENSOR_BITS + 3;

    assign dark = CW'(sample) < CW'(thr);
    assign weighted = WW'(sample) * WW'(LANE);

endmodule

// ----- hw/rtl/lcc_merge.sv -----
// Merge stage: sums the lane results into registered totals and dark counts.
module lcc_merge
    import lcc_pkg::*;
#(
    parameter int SENSOR_BITS = 10
) (
    input  logic                                     clk,
    input  logic                                     load,
    input  logic [NUM_SENSORS-1:0][SENSOR_BITS-1:0]  samples,
    input  logic [NUM_SENSORS-1:0][SENSOR_BITS+2:0]  weighted,
    input  logic [NUM_SENSORS-1:0]                   dark,
    output logic [SENSOR_BITS+2:0]                   sum,
    output logic [SENSOR_BITS+4:0]                   wsum,
    output counts_t                                  counts
);
    localparam int SW = SENSOR_BITS + 3;
    localparam int WW = SENSOR_BITS + 5;

    logic [SW-1:0] sum_reg, sum_next;
    logic [WW-1:0] wsum_reg, wsum_next;
    counts_t       counts_reg, counts_next;

    always_comb
    begin
        sum_next = '0;
        wsum_next = '0;
        counts_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            sum_next = sum_next + SW'(samples[i]);
            wsum_next = wsum_next + WW'(weighted[i]);
            counts_next.dark = counts_next.dark + DARK_W'(dark[i]);
            if (i < HALF_SENSORS)
                counts_next.left = counts_next.left + SIDE_W'(dark[i]);
            else
                counts_next.right = counts_next.right + SIDE_W'(dark[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
            wsum_reg <= wsum_next;
            counts_reg <= counts_next;
        end
    end

    assign sum = sum_reg;
    assign wsum = wsum_reg;
    assign counts = counts_reg;

endmodule

// ----- hw/rtl/lcc_divider.sv -----
// Steering scaler: gain multiply, then serial restoring divide by twice the sum.
module lcc_divider
    import lcc_pkg::*;
#(
    parameter int SENSOR_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [GAIN_W-1:0]           gain,
    input  logic [SENSOR_BITS+2:0]      sum,
    input  logic [SENSOR_BITS+4:0]      wsum,
    output logic                        busy,
    output logic                        done,
    output logic signed [STEER_W-1:0]   quotient
);
    localparam int SW = SENSOR_BITS + 3;
    localparam int NW = SENSOR_BITS + 7;
    localparam int MW = NW - 1;
    localparam int DW = SW + 1;
    localparam int PW = GAIN_W + MW;
    localparam int CNT_W = $clog2(QUO_W);

    logic [NW-1:0]     num;
    logic [MW-1:0]     mag;
    logic [GAIN_W-1:0] gain_reg;
    logic [MW-1:0]     mag_reg;
    logic [DW-1:0]     den_reg;
    logic              neg_reg, zero_reg;
    logic              mul_reg, run_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PW-1:0]     rem_reg, dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ge;
    logic signed [STEER_W-1:0] pos;

    // 2*wsum - 7*sum; both terms stay below half the range
    assign num = NW'({wsum, 1'b0}) - NW'(sum) * NW'(7);
    assign mag = num[NW-1] ? MW'(-num) : num[MW-1:0];
    assign ge = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= 1'b0;
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                mul_reg <= 1'b1;
            else if (mul_reg)
            begin
                mul_reg <= 1'b0;
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(QUO_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            gain_reg <= gain;
            mag_reg <= mag;
            neg_reg <= num[NW-1];
            zero_reg <= (sum == '0);
            den_reg <= {sum, 1'b0};
        end
        else if (mul_reg)
        begin
            rem_reg <= PW'(gain_reg) * PW'(mag_reg);
            dsh_reg <= PW'(den_reg) << (QUO_W - 1);
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    // quotient is at most 3.5 * gain, so it never needs saturation
    assign pos = $signed(STEER_W'(quo_reg));
    assign quotient = zero_reg ? '0 : (neg_reg ? -pos : pos);
    assign busy = mul_reg | run_reg;
    assign done = done_reg;

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for the line-follow course controller: streams ticks, predicts and checks.
`timescale 1ns / 1ps

module testbench;
    import lcc_pkg::*;

    localparam int SENSOR_BITS = 10;
    localparam int IN_W = NUM_SENSORS * SENSOR_BITS + TIME_W;
    localparam int SETTLE_CYCLES = 24;

    // course timing in ms
    localparam logic [TIME_W-1:0] BRAKE_WINDOW = 32'd100;
    localparam logic [TIME_W-1:0] ARM_DELAY = 32'd200;
    localparam logic [TIME_W-1:0] HARD_STEER_END = 32'd450;
    localparam logic [TIME_W-1:0] EXIT_DELAY = 32'd700;
    localparam logic [TIME_W-1:0] TURN_DONE = 32'd800;
    localparam logic [TIME_W-1:0] DETECT_GIVE_UP = 32'd2500;
    localparam logic signed [STEER_W-1:0] HARD_STEER = 16'sd40;
    localparam logic signed [STEER_W-1:0] COUNTER_STEER = 16'sd20;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [NUM_SENSORS-1:0][SENSOR_BITS-1:0] sensor;
    } tick_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [STEER_W-1:0] steer;
        mode_t mode;
    } drive_cmd_t;

    typedef enum int {
        PAT_CENTER,
        PAT_ALL_DARK,
        PAT_RIGHT_HALF,
        PAT_LEFT_HALF,
        PAT_NO_DARK,
        PAT_WIDE,
        PAT_RANDOM
    } pat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    line_follow_course_controller #(
        .SENSOR_BITS(SENSOR_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_addr(cfg_wr_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 clk = ~clk;

    // predictor copy of the registers and course state
    logic [THR_W-1:0] cfg_thr = 10'd400;
    logic [GAIN_W-1:0] cfg_strict = 12'd2000;
    logic [GAIN_W-1:0] cfg_loose = 12'd20;
    logic signed [SPEED_W-1:0] cfg_fast = 8'sd30;
    logic signed [SPEED_W-1:0] cfg_medium = 8'sd20;
    logic signed [SPEED_W-1:0] cfg_slow = 8'sd10;
    logic signed [SPEED_W-1:0] cfg_brake = -8'sd40;
    mode_t crs_mode = MODE_FOLLOW;
    det_t crs_det = DET_NONE;
    logic [TIME_W-1:0] crs_event = '0;
    logic signed [STEER_W-1:0] crs_steer = '0;

    tick_t pending_ticks[$];
    drive_cmd_t expected_cmds[$];
    tick_t cur_tick;
    logic [TIME_W-1:0] track_ms = '0;
    int ticks_queued = 0;
    int ticks_sent = 0;
    int words_checked = 0;
    int errors = 0;
    int settings_used = 1;
    int src_gap = 0;
    int sink_gap = 0;
    int span = 0;
    bit steady = 1'b0;
    logic [6:0] modes_seen = '0;

    function automatic logic signed [STEER_W-1:0] scale_steer(logic [GAIN_W-1:0] gain,
                                                              longint wsum, longint sum);
        longint g;
        longint q;
        g = longint'(gain);
        if (sum == 0)
            return '0;
        q = (g * (2 * wsum - 7 * sum)) / (2 * sum);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[STEER_W-1:0];
    endfunction

    function automatic drive_cmd_t predict_tick(tick_t t);
        longint sum;
        longint wsum;
        int dark;
        int left_n;
        int right_n;
        int i;
        logic [TIME_W-1:0] el;
        logic [TIME_W-1:0] since;
        bit to_right;
        drive_cmd_t r;
        sum = 0;
        wsum = 0;
        dark = 0;
        left_n = 0;
        right_n = 0;
        for (i = 0; i < NUM_SENSORS; i++)
        begin
            sum += longint'(t.sensor[i]);
            wsum += longint'(t.sensor[i]) * i;
            if (t.sensor[i] < cfg_thr)
            begin
                dark++;
                if (i < NUM_SENSORS / 2)
                    left_n++;
                else
                    right_n++;
            end
        end
        el = t.now_ms - crs_event;
        case (crs_mode)
            MODE_CORNER_IN:
            begin
                r.speed = (el < BRAKE_WINDOW) ? cfg_brake : cfg_slow;
                crs_steer = scale_steer(cfg_loose, wsum, sum);
                if (el > ARM_DELAY && (left_n > 3 || right_n > 3))
                begin
                    crs_event = t.now_ms;
                    crs_mode = MODE_CORNER_OUT;
                end
            end
            MODE_CORNER_OUT:
            begin
                r.speed = cfg_medium;
                crs_steer = scale_steer(cfg_strict, wsum, sum);
                if (el > EXIT_DELAY)
                begin
                    crs_event = t.now_ms;
                    crs_mode = MODE_FOLLOW;
                end
            end
            MODE_RIGHT_DET, MODE_LEFT_DET:
            begin
                r.speed = cfg_medium;
                crs_steer = scale_steer(cfg_loose, wsum, sum);
                if (dark == 0)
                begin
                    crs_event = t.now_ms;
                    if (crs_mode == MODE_RIGHT_DET)
                        crs_mode = MODE_RIGHT_TURN;
                    else
                        crs_mode = MODE_LEFT_TURN;
                end
                since = t.now_ms - crs_event;
                if (since > DETECT_GIVE_UP)
                begin
                    crs_event = t.now_ms;
                    crs_mode = MODE_FOLLOW;
                end
            end
            MODE_RIGHT_TURN, MODE_LEFT_TURN:
            begin
                to_right = (crs_mode == MODE_RIGHT_TURN);
                r.speed = cfg_medium;
                if (el < HARD_STEER_END)
                    crs_steer = to_right ? -HARD_STEER : HARD_STEER;
                else if (el < TURN_DONE)
                    crs_steer = to_right ? COUNTER_STEER : -COUNTER_STEER;
                else if (dark > 2)
                begin
                    crs_event = t.now_ms;
                    crs_mode = MODE_FOLLOW;
                end
            end
            default:
            begin
                crs_mode = MODE_FOLLOW;
                r.speed = cfg_fast;
                crs_steer = scale_steer(cfg_strict, wsum, sum);
                if (dark > 6)
                begin
                    if (crs_det == DET_CORNER)
                    begin
                        crs_event = t.now_ms;
                        crs_mode = MODE_CORNER_IN;
                    end
                    crs_det = DET_CORNER;
                end
                else if (el > ARM_DELAY && right_n > 3)
                begin
                    if (crs_det == DET_RIGHT)
                    begin
                        crs_event = t.now_ms;
                        crs_mode = MODE_RIGHT_DET;
                    end
                    crs_det = DET_RIGHT;
                end
                else if (el > ARM_DELAY && left_n > 3)
                begin
                    if (crs_det == DET_LEFT)
                    begin
                        crs_event = t.now_ms;
                        crs_mode = MODE_LEFT_DET;
                    end
                    crs_det = DET_LEFT;
                end
            end
        endcase
        r.steer = crs_steer;
        r.mode = crs_mode;
        return r;
    endfunction

    // alternate between stretches with random idling and stretches without
    always @(posedge clk)
    begin
        if (span == 0)
        begin
            steady <= ($urandom_range(0, 3) == 0);
            span <= $urandom_range(50, 400);
        end
        else
            span <= span - 1;
    end

    always @(posedge clk)
    begin : drive_blk
        logic vld_next;
        int gap_next;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            vld_next = s_axis_tvalid;
            gap_next = src_gap;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_cmds.push_back(predict_tick(cur_tick));
                ticks_sent++;
                vld_next = 1'b0;
                gap_next = steady ? 0 : $urandom_range(0, 9);
            end
            if (!vld_next)
            begin
                if (gap_next > 0)
                    gap_next--;
                else if (pending_ticks.size() > 0)
                begin
                    cur_tick = pending_ticks.pop_front();
                    s_axis_tdata <= cur_tick;
                    vld_next = 1'b1;
                end
            end
            s_axis_tvalid <= vld_next;
            src_gap <= gap_next;
        end
    end

    always @(posedge clk)
    begin : monitor_blk
        drive_cmd_t want;
        int gap_next;
        logic rdy_next;
        if (rst_n)
        begin
            gap_next = sink_gap;
            rdy_next = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word %h", $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (m_axis_tdata[7:0] !== want.speed)
                    begin
                        errors++;
                        $display("%0t: drive_speed expected %0d got %0d", $time, want.speed,
                                 $signed(m_axis_tdata[7:0]));
                    end
                    if (m_axis_tdata[23:8] !== want.steer)
                    begin
                        errors++;
                        $display("%0t: steer expected %0d got %0d", $time, want.steer,
                                 $signed(m_axis_tdata[23:8]));
                    end
                    if (m_axis_tdata[26:24] !== want.mode)
                    begin
                        errors++;
                        $display("%0t: mode_after expected %0d got %0d", $time, want.mode,
                                 m_axis_tdata[26:24]);
                    end
                    if (m_axis_tdata[26:24] < 3'd7)
                        modes_seen[m_axis_tdata[26:24]] = 1'b1;
                    words_checked++;
                end
                gap_next = steady ? 0 : $urandom_range(0, 9);
                rdy_next = (gap_next == 0);
            end
            else if (!m_axis_tready)
            begin
                if (gap_next > 0)
                    gap_next--;
                rdy_next = (gap_next == 0);
            end
            m_axis_tready <= rdy_next;
            sink_gap <= gap_next;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_DARK_THR: cfg_thr = val[THR_W-1:0];
            REG_STRICT: cfg_strict = val[GAIN_W-1:0];
            REG_LOOSE: cfg_loose = val[GAIN_W-1:0];
            REG_FAST: cfg_fast = val[SPEED_W-1:0];
            REG_MEDIUM: cfg_medium = val[SPEED_W-1:0];
            REG_SLOW: cfg_slow = val[SPEED_W-1:0];
            REG_BRAKE: cfg_brake = val[SPEED_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [THR_W-1:0] thr, logic [GAIN_W-1:0] sg,
                             logic [GAIN_W-1:0] lg, logic [SPEED_W-1:0] fs,
                             logic [SPEED_W-1:0] ms, logic [SPEED_W-1:0] ss,
                             logic [SPEED_W-1:0] bs);
        write_reg(REG_DARK_THR, CFG_DATA_W'(thr));
        write_reg(REG_STRICT, sg);
        write_reg(REG_LOOSE, lg);
        write_reg(REG_FAST, CFG_DATA_W'(fs));
        write_reg(REG_MEDIUM, CFG_DATA_W'(ms));
        write_reg(REG_SLOW, CFG_DATA_W'(ss));
        write_reg(REG_BRAKE, CFG_DATA_W'(bs));
        settings_used++;
    endtask

    // hold until every queued tick has been answered, then let the pipe drain
    task automatic settle();
        while (words_checked != ticks_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SENSOR_BITS-1:0] shade(bit want_dark);
        if (want_dark && cfg_thr != 0)
        begin
            if ($urandom_range(0, 7) == 0)
                return '0;
            return SENSOR_BITS'($urandom_range(0, cfg_thr - 1));
        end
        if ($urandom_range(0, 7) == 0)
            return '1;
        return SENSOR_BITS'($urandom_range(cfg_thr, 2 ** SENSOR_BITS - 1));
    endfunction

    task automatic push_mask(logic [NUM_SENSORS-1:0] dark_mask, int step);
        tick_t t;
        int i;
        track_ms = track_ms + step;
        t.now_ms = track_ms;
        for (i = 0; i < NUM_SENSORS; i++)
            t.sensor[i] = dark_mask[i] ? '0 : '1;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic push_tick(pat_t p, int step);
        tick_t t;
        logic [NUM_SENSORS-1:0] m;
        int i;
        int w;
        track_ms = track_ms + step;
        t.now_ms = track_ms;
        case (p)
            PAT_CENTER:
                m = ($urandom_range(0, 1) ? 8'b11 : 8'b01) << $urandom_range(1, 5);
            PAT_ALL_DARK:
                m = 8'hFF & ~(8'($urandom_range(0, 1)) << $urandom_range(0, 7));
            PAT_RIGHT_HALF:
                m = 8'hF0 | (8'($urandom_range(0, 1)) << $urandom_range(0, 3));
            PAT_LEFT_HALF:
                m = 8'h0F | (8'($urandom_range(0, 1)) << $urandom_range(4, 7));
            PAT_WIDE:
            begin
                w = $urandom_range(3, 5);
                m = ((8'd1 << w) - 8'd1) << $urandom_range(0, 8 - w);
            end
            default:
                m = '0;
        endcase
        for (i = 0; i < NUM_SENSORS; i++)
            t.sensor[i] = (p == PAT_RANDOM) ? SENSOR_BITS'($urandom_range(0, 1023))
                                            : shade(m[i]);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic push_run(pat_t p, int n, int lo, int hi);
        repeat (n) push_tick(p, $urandom_range(lo, hi));
    endtask

    task automatic corner_course();
        push_run(PAT_CENTER, $urandom_range(2, 5), 20, 80);
        push_run(PAT_ALL_DARK, $urandom_range(2, 3), 5, 30);
        repeat ($urandom_range(3, 12))
            push_tick($urandom_range(0, 1) ? PAT_CENTER : PAT_RANDOM, $urandom_range(10, 40));
        push_run($urandom_range(0, 1) ? PAT_RIGHT_HALF : PAT_LEFT_HALF,
                 $urandom_range(1, 2), 20, 60);
        push_run(PAT_CENTER, $urandom_range(10, 30), 20, 60);
    endtask

    task automatic lane_course();
        pat_t side;
        side = $urandom_range(0, 1) ? PAT_RIGHT_HALF : PAT_LEFT_HALF;
        push_run(PAT_CENTER, $urandom_range(3, 6), 40, 90);
        push_run(side, $urandom_range(2, 3), 20, 60);
        repeat ($urandom_range(0, 4))
            push_tick($urandom_range(0, 1) ? PAT_WIDE : PAT_CENTER, $urandom_range(20, 60));
        if ($urandom_range(0, 3) == 0)
            // no gap in the line: let detection give up
            push_run(PAT_CENTER, $urandom_range(40, 80), 30, 60);
        else
        begin
            push_tick(PAT_NO_DARK, $urandom_range(10, 40));
            push_run($urandom_range(0, 1) ? PAT_CENTER : PAT_NO_DARK,
                     $urandom_range(15, 35), 30, 60);
            push_run(PAT_WIDE, $urandom_range(1, 2), 20, 60);
        end
    endtask

    task automatic noise_course();
        repeat ($urandom_range(5, 20))
        begin
            if ($urandom_range(0, 15) == 0)
                track_ms = $urandom;
            push_tick(pat_t'($urandom_range(0, 6)), $urandom_range(0, 300));
        end
    endtask

    task automatic run_phase(int n);
        int target;
        int pick;
        target = ticks_queued + n;
        while (ticks_queued < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                corner_course();
            else if (pick < 8)
                lane_course();
            else
                noise_course();
        end
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sum, corner with brake, exit; both lane changes, turn phases, give-up
        push_mask(8'hFF, 1000);
        push_mask(8'hFF, 10);
        push_mask(8'h00, 30);
        push_mask(8'h80, 150);
        push_mask(8'hF0, 50);
        push_mask(8'h01, 300);
        push_mask(8'h00, 500);
        push_mask(8'hF0, 300);
        push_mask(8'hF0, 20);
        push_mask(8'h18, 50);
        push_mask(8'h00, 20);
        push_mask(8'h00, 400);
        push_mask(8'h00, 300);
        push_mask(8'h00, 200);
        push_mask(8'hFF, 20);
        push_mask(8'h0F, 300);
        push_mask(8'h0F, 20);
        push_mask(8'h0F, 2600);
        push_mask(8'h0F, 300);
        push_mask(8'h00, 10);
        push_mask(8'h00, 100);
        push_mask(8'h00, 500);
        push_mask(8'h00, 300);
        push_mask(8'hFF, 10);
        push_mask(8'h55, 300);
        settle();

        run_phase(250);

        write_all(THR_W'($urandom_range(100, 900)), GAIN_W'($urandom), GAIN_W'($urandom),
                  SPEED_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom),
                  SPEED_W'($urandom));
        run_phase(250);

        write_all(10'd1023, 12'd4095, 12'd4095, 8'h7F, 8'h7F, 8'h7F, 8'h80);
        run_phase(200);

        write_all(10'd0, 12'd0, 12'd0, 8'h80, 8'h80, 8'h80, 8'h7F);
        run_phase(100);

        // cross the 32-bit wrap of the timestamp
        track_ms = 32'hFFFF_F000;
        write_all(THR_W'($urandom_range(1, 1023)), GAIN_W'($urandom), GAIN_W'($urandom),
                  SPEED_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom),
                  SPEED_W'($urandom));
        run_phase(250);

        write_all(10'd400, 12'd2000, 12'd20, 8'd30, 8'd20, 8'd10, 8'hD8);
        run_phase(250);

        settle();
        if (expected_cmds.size() != 0)
            errors++;
        $display("Drove %0d ticks and checked %0d result words over %0d register settings",
                 ticks_sent, words_checked, settings_used);
        $display("Course modes reached (bit per mode): %b, failing checks: %0d",
                 modes_seen, errors);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d of %0d words checked", words_checked, ticks_queued);
        $display("Mismatches found");
        $finish;
    end

endmodule
